### design/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and the lead byte classifier for the strict
// UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
    localparam logic [7:0]  LEAD2_MIN   = 8'hC2;
    localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
    localparam logic [7:0]  LEAD3_SURR  = 8'hED;
    localparam logic [7:0]  LEAD4_MIN   = 8'hF0;
    localparam logic [7:0]  LEAD4_MAX   = 8'hF4;
    localparam logic [7:0]  TRAIL_LO    = 8'h80;
    localparam logic [7:0]  TRAIL_HI    = 8'hBF;
    localparam logic [7:0]  E0_TRAIL_LO = 8'hA0;
    localparam logic [7:0]  ED_TRAIL_HI = 8'h9F;
    localparam logic [7:0]  F0_TRAIL_LO = 8'h90;
    localparam logic [7:0]  F4_TRAIL_HI = 8'h8F;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [5:0]  HI_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LO_SURR_TAG = 6'b110111;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One queue entry: all units that one input byte produces.
    typedef struct packed {
        logic [15:0] unit0;
        logic        repl0;
        logic [15:0] unit1;
        logic        repl1;
        logic        two;
        logic        fin;
    } entry_t;

    typedef struct packed {
        logic        full;
        logic        valid;
    } q_stat_t;

    typedef struct packed {
        logic [1:0]  trails;
        logic        invalid;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [20:0] payload;
    } lead_info_t;

    function automatic lead_info_t lead_class(input logic [7:0] b);
        lead_info_t r;
        r.trails  = 2'd0;
        r.invalid = 1'b0;
        r.lo      = TRAIL_LO;
        r.hi      = TRAIL_HI;
        r.payload = '0;
        if (b[7] == 1'b0) begin
            r.trails = 2'd0;
        end else if (b < LEAD2_MIN) begin
            r.invalid = 1'b1;
        end else if (b < LEAD3_MIN) begin
            r.trails  = 2'd1;
            r.payload = {16'd0, b[4:0]};
        end else if (b < LEAD4_MIN) begin
            r.trails  = 2'd2;
            r.payload = {17'd0, b[3:0]};
            if (b == LEAD3_MIN) begin
                r.lo = E0_TRAIL_LO;
            end
            if (b == LEAD3_SURR) begin
                r.hi = ED_TRAIL_HI;
            end
        end else if (b <= LEAD4_MAX) begin
            r.trails  = 2'd3;
            r.payload = {18'd0, b[2:0]};
            if (b == LEAD4_MIN) begin
                r.lo = F0_TRAIL_LO;
            end
            if (b == LEAD4_MAX) begin
                r.hi = F4_TRAIL_HI;
            end
        end else begin
            r.invalid = 1'b1;
        end
        return r;
    endfunction

endpackage

### design/u8u16_front.sv
// ----------------------------------------------------------------------------
// u8u16_front
// Byte acceptance and decode: tracks the open sequence and builds one queue
// entry with up to two code units per byte.
// ----------------------------------------------------------------------------
module u8u16_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic                s_tlast,
    input  u8u16_pkg::q_stat_t  q_stat,
    output logic                q_push,
    output u8u16_pkg::entry_t   q_entry
);

    logic [1:0]  trails_reg, trails_next;
    logic        first_reg, first_next;
    logic [7:0]  lead_reg, lead_next;
    logic [20:0] cp_reg, cp_next;

    u8u16_pkg::lead_info_t info_lead, info_b;
    logic        accept;
    logic        seq_open, trail_ok, take, reject, complete;
    logic [1:0]  trails_dec;
    logic [20:0] cp_take;
    logic [19:0] supp_v;
    logic [1:0]  cnt;
    u8u16_pkg::entry_t ent;

    assign s_tready  = !q_stat.full;
    assign accept    = s_tvalid && s_tready;
    assign info_lead = u8u16_pkg::lead_class(lead_reg);
    assign info_b    = u8u16_pkg::lead_class(s_tdata);

    assign seq_open   = (trails_reg != 2'd0);
    assign trail_ok   = first_reg ? (s_tdata >= info_lead.lo && s_tdata <= info_lead.hi)
                                  : (s_tdata[7:6] == 2'b10);
    assign take       = seq_open && trail_ok;
    assign reject     = seq_open && !trail_ok;
    assign trails_dec = trails_reg - 2'd1;
    assign cp_take    = {cp_reg[14:0], s_tdata[5:0]};
    assign complete   = take && (trails_dec == 2'd0);
    assign supp_v     = 20'(cp_take - u8u16_pkg::SUPP_BASE);

    always_comb begin
        cnt         = 2'd0;
        ent         = '0;
        trails_next = trails_reg;
        first_next  = first_reg;
        lead_next   = lead_reg;
        cp_next     = cp_reg;

        if (reject) begin
            ent.unit0   = u8u16_pkg::REPL_UNIT;
            ent.repl0   = 1'b1;
            cnt         = 2'd1;
            trails_next = 2'd0;
            first_next  = 1'b0;
            lead_next   = '0;
            cp_next     = '0;
        end

        if (take) begin
            if (complete) begin
                trails_next = 2'd0;
                first_next  = 1'b0;
                lead_next   = '0;
                cp_next     = '0;
                if (cp_take >= u8u16_pkg::SUPP_BASE) begin
                    ent.unit0 = {u8u16_pkg::HI_SURR_TAG, supp_v[19:10]};
                    ent.unit1 = {u8u16_pkg::LO_SURR_TAG, supp_v[9:0]};
                    cnt       = 2'd2;
                end else begin
                    ent.unit0 = cp_take[15:0];
                    cnt       = 2'd1;
                end
            end else begin
                trails_next = trails_dec;
                first_next  = 1'b0;
                cp_next     = cp_take;
            end
        end else begin
            if (info_b.trails != 2'd0) begin
                trails_next = info_b.trails;
                first_next  = 1'b1;
                lead_next   = s_tdata;
                cp_next     = info_b.payload;
            end else begin
                if (cnt == 2'd0) begin
                    ent.unit0 = info_b.invalid ? u8u16_pkg::REPL_UNIT : {8'd0, s_tdata};
                    ent.repl0 = info_b.invalid;
                end else begin
                    ent.unit1 = info_b.invalid ? u8u16_pkg::REPL_UNIT : {8'd0, s_tdata};
                    ent.repl1 = info_b.invalid;
                end
                cnt = cnt + 2'd1;
            end
        end

        // end of string closes any open sequence with a replacement
        if (s_tlast && trails_next != 2'd0) begin
            if (cnt == 2'd0) begin
                ent.unit0 = u8u16_pkg::REPL_UNIT;
                ent.repl0 = 1'b1;
            end else begin
                ent.unit1 = u8u16_pkg::REPL_UNIT;
                ent.repl1 = 1'b1;
            end
            cnt         = cnt + 2'd1;
            trails_next = 2'd0;
            first_next  = 1'b0;
            lead_next   = '0;
            cp_next     = '0;
        end

        ent.two = (cnt == 2'd2);
        ent.fin = s_tlast;
    end

    assign q_push  = accept && (cnt != 2'd0);
    assign q_entry = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trails_reg <= 2'd0;
            first_reg  <= 1'b0;
            lead_reg   <= '0;
            cp_reg     <= '0;
        end else if (accept) begin
            trails_reg <= trails_next;
            first_reg  <= first_next;
            lead_reg   <= lead_next;
            cp_reg     <= cp_next;
        end
    end

    a_eos_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |-> q_push)
        else $error("end of string byte produced no unit");
    a_eos_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> trails_reg == 2'd0)
        else $error("sequence left open after end of string");
    a_first_only_open: assert property (@(posedge aclk) disable iff (!aresetn)
        first_reg |-> trails_reg != 2'd0)
        else $error("first trail flag without open sequence");

endmodule

### design/u8u16_queue.sv
// ----------------------------------------------------------------------------
// u8u16_queue
// Small entry queue between the decode front and the unit serializer.
// ----------------------------------------------------------------------------
module u8u16_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  u8u16_pkg::entry_t  push_entry,
    input  logic               pop,
    output u8u16_pkg::entry_t  head,
    output u8u16_pkg::q_stat_t stat
);

    u8u16_pkg::entry_t              mem_reg [u8u16_pkg::QUEUE_DEPTH];
    logic [u8u16_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [u8u16_pkg::QUEUE_AW:0]   count_reg, count_next;

    assign stat.full  = (count_reg == (u8u16_pkg::QUEUE_AW+1)'(u8u16_pkg::QUEUE_DEPTH));
    assign stat.valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && stat.full))
        else $error("queue write while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !stat.valid))
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (u8u16_pkg::QUEUE_AW+1)'(u8u16_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

### design/u8u16_back.sv
// ----------------------------------------------------------------------------
// u8u16_back
// Unit serializer: sends the units of each queue entry one per transaction
// through the output register.
// ----------------------------------------------------------------------------
module u8u16_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  u8u16_pkg::entry_t  head,
    input  u8u16_pkg::q_stat_t q_stat,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,   // [15:0] code_unit
    output logic               m_tlast,
    output logic               m_tuser    // [0] was_replaced
);

    logic        valid_reg;
    logic        sel_reg, sel_next;
    logic [15:0] data_reg;
    logic        last_reg, user_reg;
    logic        load, last_of_entry;

    assign load          = q_stat.valid && (!valid_reg || m_tready);
    assign last_of_entry = sel_reg || !head.two;
    assign pop           = load && last_of_entry;

    always_comb begin
        sel_next = sel_reg;
        if (load) begin
            sel_next = !last_of_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= sel_reg ? head.unit1 : head.unit0;
            user_reg <= sel_reg ? head.repl1 : head.repl0;
            last_reg <= last_of_entry && head.fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            sel_reg <= sel_next;
            if (load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

    a_second_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        sel_reg |-> q_stat.valid && head.two)
        else $error("second unit pending without a two-unit head entry");
    a_pair_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        load && !last_of_entry |=> sel_reg)
        else $error("second unit of entry skipped");

endmodule

### design/utf8_to_utf16_strict_decoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_strict_decoder_core
// Strict UTF-8 to UTF-16 stream decoder, top level.
// ----------------------------------------------------------------------------
// The block accepts one UTF-8 byte per cycle on the s_ side with tlast marking
// the end of the string, and delivers UTF-16 code units on the m_ side, one
// per transaction, with tlast on the last unit of the string and tuser set on
// a substituted U+FFFD. Each byte yields zero, one or two units; they are
// written as one entry into a four-entry queue in the cycle the byte is
// accepted; the output register then loads the first unit from the queue
// head. While m_tready is high the output side moves one unit per cycle, so
// the sustained input rate is one byte per cycle except where bytes produce
// two units (surrogate pairs, or a replacement followed by a fresh unit), where
// the output register sets the pace and s_tready drops once the queue fills.
module utf8_to_utf16_strict_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] code_unit
    output logic        m_tlast,
    output logic        m_tuser    // [0] was_replaced
);

    u8u16_pkg::q_stat_t q_stat;
    u8u16_pkg::entry_t  push_entry, head;
    logic               push, pop;

    u8u16_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .q_push   (push),
        .q_entry  (push_entry)
    );

    u8u16_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    u8u16_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### bench/utf8_to_utf16_strict_decoder_core_checker.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_strict_decoder_core_checker
// Watches both stream channels of the strict UTF-8 to UTF-16 decoder. It
// decodes every accepted byte with its own model of the decoder state, queues
// the UTF-16 units that the byte should produce, and compares each delivered
// unit field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module utf8_to_utf16_strict_decoder_core_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] code_unit
    input  logic        m_tlast,
    input  logic        m_tuser,   // [0] was_replaced
    output int          fail_count,
    output int          pending_units,
    output int          units_checked,
    output int          replacements_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        final_unit;
        logic        was_replaced;
    } utf16_unit_t;

    utf16_unit_t expected_units[$];
    utf16_unit_t byte_units[$];

    logic [1:0]  trails_left;
    logic        first_trail_pending;
    logic [7:0]  open_lead;
    logic [20:0] code_point_acc;

    int errs     = 0;
    int checked  = 0;
    int repl_cnt = 0;

    // trail count (0 = ASCII, -1 = byte that cannot start a character) and allowed range of the first trail
    function automatic void lead_range(input logic [7:0] b, output int n,
                                       output logic [7:0] lo, output logic [7:0] hi);
        lo = u8u16_pkg::TRAIL_LO;
        hi = u8u16_pkg::TRAIL_HI;
        if (b < u8u16_pkg::TRAIL_LO) begin
            n = 0;
        end else if (b < u8u16_pkg::LEAD2_MIN) begin
            n = -1;
        end else if (b < u8u16_pkg::LEAD3_MIN) begin
            n = 1;
        end else if (b < u8u16_pkg::LEAD4_MIN) begin
            n = 2;
            if (b == u8u16_pkg::LEAD3_MIN) lo = u8u16_pkg::E0_TRAIL_LO;
            if (b == u8u16_pkg::LEAD3_SURR) hi = u8u16_pkg::ED_TRAIL_HI;
        end else if (b <= u8u16_pkg::LEAD4_MAX) begin
            n = 3;
            if (b == u8u16_pkg::LEAD4_MIN) lo = u8u16_pkg::F0_TRAIL_LO;
            if (b == u8u16_pkg::LEAD4_MAX) hi = u8u16_pkg::F4_TRAIL_HI;
        end else begin
            n = -1;
        end
    endfunction

    task automatic add_unit(input logic [15:0] cu, input logic repl);
        utf16_unit_t u;
        if (byte_units.size() < 2) begin
            u.code_unit    = cu;
            u.final_unit   = 1'b0;
            u.was_replaced = repl;
            byte_units.push_back(u);
        end
    endtask

    task automatic close_open_seq();
        trails_left         = 2'd0;
        first_trail_pending = 1'b0;
        open_lead           = 8'h00;
        code_point_acc      = '0;
    endtask

    task automatic open_fresh(input logic [7:0] b);
        int n;
        logic [7:0] lo;
        logic [7:0] hi;
        lead_range(b, n, lo, hi);
        if (n == 0) begin
            add_unit({8'h00, b}, 1'b0);
        end else if (n < 0) begin
            add_unit(u8u16_pkg::REPL_UNIT, 1'b1);
        end else begin
            trails_left         = n[1:0];
            first_trail_pending = 1'b1;
            open_lead           = b;
            if (n == 1) code_point_acc = {16'd0, b[4:0]};
            else if (n == 2) code_point_acc = {17'd0, b[3:0]};
            else code_point_acc = {18'd0, b[2:0]};
        end
    endtask

    task automatic absorb_trail(input logic [7:0] b);
        logic [20:0] cp;
        logic [20:0] offs;
        code_point_acc      = {code_point_acc[14:0], b[5:0]};
        first_trail_pending = 1'b0;
        trails_left         = trails_left - 2'd1;
        if (trails_left == 2'd0) begin
            cp = code_point_acc;
            close_open_seq();
            if (cp >= u8u16_pkg::SUPP_BASE) begin
                offs = cp - u8u16_pkg::SUPP_BASE;
                add_unit({u8u16_pkg::HI_SURR_TAG, offs[19:10]}, 1'b0);
                add_unit({u8u16_pkg::LO_SURR_TAG, offs[9:0]}, 1'b0);
            end else begin
                add_unit(cp[15:0], 1'b0);
            end
        end
    endtask

    task automatic reject_and_restart(input logic [7:0] b);
        close_open_seq();
        add_unit(u8u16_pkg::REPL_UNIT, 1'b1);
        open_fresh(b);
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eos);
        int n;
        logic [7:0] lo;
        logic [7:0] hi;
        utf16_unit_t u;
        byte_units.delete();
        if (trails_left == 2'd0) begin
            open_fresh(b);
        end else if (first_trail_pending) begin
            lead_range(open_lead, n, lo, hi);
            if (b >= lo && b <= hi) absorb_trail(b);
            else reject_and_restart(b);
        end else begin
            if (b[7:6] == 2'b10) absorb_trail(b);
            else reject_and_restart(b);
        end
        if (eos) begin
            if (trails_left != 2'd0) begin
                close_open_seq();
                add_unit(u8u16_pkg::REPL_UNIT, 1'b1);
            end
            if (byte_units.size() > 0) begin
                u = byte_units.pop_back();
                u.final_unit = 1'b1;
                byte_units.push_back(u);
            end
        end
        foreach (byte_units[i]) expected_units.push_back(byte_units[i]);
    endtask

    always @(posedge aclk) begin
        utf16_unit_t want;
        if (!aresetn) begin
            close_open_seq();
            expected_units.delete();
        end else begin
            if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_units.size() == 0) begin
                    $error("unexpected unit: code_unit %h, final_unit %b, was_replaced %b",
                           m_tdata, m_tlast, m_tuser);
                    errs++;
                end else begin
                    want = expected_units.pop_front();
                    checked++;
                    if (want.was_replaced) repl_cnt++;
                    if (m_tdata !== want.code_unit) begin
                        $error("code_unit mismatch: expected %h, actual %h",
                               want.code_unit, m_tdata);
                        errs++;
                    end
                    if (m_tlast !== want.final_unit) begin
                        $error("final_unit mismatch: expected %b, actual %b",
                               want.final_unit, m_tlast);
                        errs++;
                    end
                    if (m_tuser !== want.was_replaced) begin
                        $error("was_replaced mismatch: expected %b, actual %b",
                               want.was_replaced, m_tuser);
                        errs++;
                    end
                end
            end
        end
        fail_count        <= errs;
        pending_units     <= expected_units.size();
        units_checked     <= checked;
        replacements_seen <= repl_cnt;
    end

endmodule

### bench/utf8_to_utf16_strict_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_strict_decoder_core_tb
// Drives UTF-8 strings into the strict decoder: a directed set of edge-case
// byte sequences, then random strings made mostly of well-formed characters
// with truncated sequences, broken trails and stray bytes mixed in. Both
// sides idle at random and the receiver once stalls long enough to back up
// the block. A checker module beside the block does all the comparing.
// ----------------------------------------------------------------------------
module utf8_to_utf16_strict_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 2000;
    localparam int STALL_AT     = 300;
    localparam int STALL_CYCLES = 400;
    localparam int NDIR         = 27;

    localparam logic [7:0] DIR_BYTES [NDIR] = '{
        8'h00, 8'h7F,
        8'hC2, 8'h80,
        8'hE0, 8'hA0, 8'h80,
        8'hE0, 8'h9F,
        8'hED, 8'hA0,
        8'hF0, 8'h90, 8'h80, 8'h80,
        8'hF4, 8'h8F, 8'hBF, 8'hBF,
        8'hF4, 8'h90,
        8'hFF,
        8'h80,
        8'hE1, 8'h80, 8'h41,
        8'hC3
    };
    localparam logic DIR_EOS [NDIR] = '{
        1'b0, 1'b1,
        1'b0, 1'b0,
        1'b0, 1'b0, 1'b0,
        1'b0, 1'b0,
        1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0,
        1'b1,
        1'b0,
        1'b0, 1'b0, 1'b0,
        1'b1
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;            // [15:0] code_unit
    logic        m_tlast;
    logic        m_tuser;            // [0] was_replaced

    int fail_count;
    int pending_units;
    int units_checked;
    int replacements_seen;

    int  bytes_sent   = 0;
    int  strings_sent = 0;
    bit  tx_quiet     = 1'b0;
    bit  rx_quiet     = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    utf8_to_utf16_strict_decoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    utf8_to_utf16_strict_decoder_core_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tlast           (s_tlast),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .m_tuser           (m_tuser),
        .fail_count        (fail_count),
        .pending_units     (pending_units),
        .units_checked     (units_checked),
        .replacements_seen (replacements_seen)
    );

    function automatic int draw_gap(input bit quiet);
        if (quiet || $urandom_range(0, 2) != 0) return 0;
        return $urandom_range(0, 17);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos);
        int gap;
        if (bytes_sent % 128 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eos;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        if (eos) strings_sent++;
    endtask

    function automatic logic random_eos();
        return ($urandom_range(0, 11) == 0);
    endfunction

    // one character: mostly well formed, sometimes cut short, corrupted or noise
    task automatic send_random_char();
        logic [7:0] seq [4];
        logic [7:0] lo;
        logic [7:0] hi;
        int kind;
        int len;
        int keep;
        kind = $urandom_range(0, 99);
        if (kind >= 92) begin
            send_byte(8'($urandom_range(0, 255)), random_eos());
            return;
        end
        if (kind < 30) begin
            len    = 1;
            seq[0] = 8'($urandom_range(0, 8'h7F));
        end else begin
            if (kind < 50) begin
                len    = 2;
                seq[0] = 8'($urandom_range(u8u16_pkg::LEAD2_MIN, 8'hDF));
            end else if (kind < 68) begin
                len    = 3;
                seq[0] = 8'($urandom_range(u8u16_pkg::LEAD3_MIN, 8'hEF));
            end else begin
                len    = 4;
                seq[0] = 8'($urandom_range(u8u16_pkg::LEAD4_MIN, u8u16_pkg::LEAD4_MAX));
            end
            lo = u8u16_pkg::TRAIL_LO;
            hi = u8u16_pkg::TRAIL_HI;
            if (seq[0] == u8u16_pkg::LEAD3_MIN) lo = u8u16_pkg::E0_TRAIL_LO;
            if (seq[0] == u8u16_pkg::LEAD3_SURR) hi = u8u16_pkg::ED_TRAIL_HI;
            if (seq[0] == u8u16_pkg::LEAD4_MIN) lo = u8u16_pkg::F0_TRAIL_LO;
            if (seq[0] == u8u16_pkg::LEAD4_MAX) hi = u8u16_pkg::F4_TRAIL_HI;
            seq[1] = 8'($urandom_range(lo, hi));
            for (int i = 2; i < len; i++) begin
                seq[i] = 8'($urandom_range(u8u16_pkg::TRAIL_LO, u8u16_pkg::TRAIL_HI));
            end
        end
        keep = len;
        if (len > 1 && kind >= 84) begin
            if ($urandom_range(0, 1) == 0) begin
                keep = $urandom_range(1, len - 1);
            end else begin
                seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
            end
        end
        for (int i = 0; i < keep; i++) send_byte(seq[i], random_eos());
    endtask

    // receiver: random idling plus one long hold-off to back up the block
    initial begin
        int taken;
        int hold;
        taken = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken % 100 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            if (taken == STALL_AT) hold = STALL_CYCLES;
            else hold = draw_gap(rx_quiet);
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NDIR; i++) send_byte(DIR_BYTES[i], DIR_EOS[i]);

        while (bytes_sent < NDIR + RANDOM_BYTES) send_random_char();
        send_byte(8'h0A, 1'b1);
        s_tvalid <= 1'b0;
        @(posedge aclk);

        while (pending_units != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d bytes in %0d strings; checked %0d UTF-16 units (%0d replacements).",
                 bytes_sent, strings_sent, units_checked, replacements_seen);
        if (fail_count == 0 && pending_units == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### utf8_to_utf16_strict_decoder_core.f
design/u8u16_pkg.sv
design/u8u16_front.sv
design/u8u16_queue.sv
design/u8u16_back.sv
design/utf8_to_utf16_strict_decoder_core.sv
bench/utf8_to_utf16_strict_decoder_core_checker.sv
bench/utf8_to_utf16_strict_decoder_core_tb.sv
